### rtl/core/assert_macros.svh
// Assertion helper macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SHIM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define SHIM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/shim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shim_pkg
// Shared types and command codes for the strip hit interval monitor.
// ----------------------------------------------------------------------------
package shim_pkg;

   localparam logic [1:0] CMD_RECORD  = 2'd0;
   localparam logic [1:0] CMD_LAST    = 2'd1;
   localparam logic [1:0] CMD_ELAPSED = 2'd2;
   // spare code, answered like a last-time query
   localparam logic [1:0] CMD_SPARE   = 2'd3;

   localparam int MEAN_W  = 40;
   localparam int COUNT_W = 32;
   localparam int EVT_W   = 31;
   localparam int CHG_W   = 16;
   localparam int ELAP_W  = 33;

   // One classified item as it travels from front to back
   typedef struct packed {
      logic [1:0]  cmd;
      logic        valid_chan;
      logic [16:0] slot;
      logic [30:0] event_number;
      logic [30:0] digi_number;
      logic [47:0] time_stamp;
      logic [15:0] charge;
   } item_type;

endpackage

### rtl/core/strip_hit_interval_monitor_core.sv
`timescale 1ns / 1ps
// A query is answered in the eval state after the record read; a first hit goes on to
// write back, and a hit on a channel hit before first runs the divider (50 divider steps).
// The back part works on one item at a time; a two-entry queue takes items while it works.
// Reset: synchronous. After it a clearing pass over all 2*CHANNELS slots zeroes the hit
// counts and means; the queue takes two transfers meanwhile, then busy holds start.
// The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
// strip_hit_interval_monitor_core
// Per-channel hit record with running mean interval, for both sensor sides.
// ----------------------------------------------------------------------------
module strip_hit_interval_monitor_core #(
   parameter int CHANNELS  = 1024,
   parameter int TIME_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic               req_side,
   input  logic [9:0]         req_channel,
   input  logic [30:0]        req_event_number,
   input  logic [30:0]        req_digi_number,
   input  logic [31:0]        req_time_stamp,
   input  logic [15:0]        req_charge,
   output logic               rsp_valid,
   output logic               rsp_never_hit,
   output logic [31:0]        rsp_last_time,
   output logic signed [32:0] rsp_elapsed,
   output logic signed [39:0] rsp_mean_interval,
   output logic [31:0]        rsp_hit_count,
   output logic [15:0]        rsp_last_charge,
   output logic [30:0]        rsp_last_event,
   output logic [30:0]        rsp_last_digi
);
   logic               accept, full, q_valid, q_pop;
   shim_pkg::item_type q_item;

   // a transfer happens when start meets a free queue slot
   assign busy   = full;
   assign accept = start && !busy;

   shim_front #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_front (
      .clock(clock), .reset(reset), .accept(accept), .cmd(req_cmd), .side(req_side),
      .channel(req_channel), .event_number(req_event_number),
      .digi_number(req_digi_number), .time_stamp(req_time_stamp),
      .charge(req_charge), .full(full), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop));

   // back part: record read, divide, write back, answer
   shim_back #(.CHANNELS(CHANNELS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop), .rsp_valid(rsp_valid),
      .rsp_never_hit(rsp_never_hit), .rsp_last_time(rsp_last_time),
      .rsp_elapsed(rsp_elapsed), .rsp_mean_interval(rsp_mean_interval),
      .rsp_hit_count(rsp_hit_count), .rsp_last_charge(rsp_last_charge),
      .rsp_last_event(rsp_last_event), .rsp_last_digi(rsp_last_digi));
endmodule

### rtl/core/shim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shim_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shim_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/shim_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shim_front
// Accept items, check the channel range, form the slot and queue the item.
// Two-entry queue toward the back part.
// ----------------------------------------------------------------------------
module shim_front #(
   parameter int CHANNELS  = 1024,
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              cmd,
   input  logic                    side,
   input  logic [9:0]              channel,
   input  logic [30:0]             event_number,
   input  logic [30:0]             digi_number,
   input  logic [31:0]             time_stamp,
   input  logic [15:0]             charge,
   output logic                    full,
   output logic                    q_valid,
   output shim_pkg::item_type      q_item,
   input  logic                    q_pop
);
   localparam int SLOT_W = $clog2(2 * CHANNELS);

   shim_pkg::item_type entry_ff [2];
   shim_pkg::item_type item_in;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [47:0] ts_ext;
   logic [16:0] slot_full;

   always_comb begin
      ts_ext = {16'd0, time_stamp};
      if (TIME_BITS < 48) begin
         ts_ext = ts_ext & ((48'd1 << TIME_BITS) - 48'd1);
      end
      slot_full = (17'(side) * 17'(CHANNELS)) + 17'(channel);
      item_in.cmd          = cmd;
      item_in.valid_chan   = (17'(channel) < 17'(CHANNELS));
      item_in.slot         = 17'(slot_full[SLOT_W-1:0]);
      item_in.event_number = event_number;
      item_in.digi_number  = digi_number;
      item_in.time_stamp   = ts_ext;
      item_in.charge       = charge;
   end

   assign count_in = count_ff + 2'(accept) - 2'(q_pop);
   assign full     = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end
endmodule

### rtl/core/shim_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shim_divider
// Signed by unsigned restoring divider, one quotient bit a cycle, truncated.
// ----------------------------------------------------------------------------
module shim_divider #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0]        denom,
   output logic                    done,
   output logic signed [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic             neg_ff, busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   trial;
   logic [NUM_W-1:0] mag;

   assign mag   = numer[NUM_W-1] ? (~numer + 1'b1) : numer;
   assign trial = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
            q_ff    <= mag;
            rem_ff  <= '0;
            den_ff  <= denom;
            neg_ff  <= numer[NUM_W-1];
         end else if (busy_ff) begin
            // shift in one dividend bit, subtract where it fits
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= trial - {1'b0, den_ff};
               q_ff   <= {q_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial;
               q_ff   <= {q_ff[NUM_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   assign quot = neg_ff ? (~q_ff + 1'b1) : q_ff;
endmodule

### rtl/core/shim_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shim_back
// Take one queued item, read the channel record, update it on a record command and answer.
// ----------------------------------------------------------------------------
module shim_back #(
   parameter int CHANNELS  = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  shim_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output logic                 rsp_never_hit,
   output logic [31:0]          rsp_last_time,
   output logic signed [32:0]   rsp_elapsed,
   output logic signed [39:0]   rsp_mean_interval,
   output logic [31:0]          rsp_hit_count,
   output logic [15:0]          rsp_last_charge,
   output logic [30:0]          rsp_last_event,
   output logic [30:0]          rsp_last_digi
);
   localparam int DEPTH  = 2 * CHANNELS;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CLR_W  = $clog2(DEPTH + 1);
   localparam int NUM_W  = 50;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   logic [2:0]          state_ff;
   logic [CLR_W-1:0]    clr_ff;
   shim_pkg::item_type  it_ff;
   logic signed [39:0]  newmean_ff;
   logic                div_start;
   logic                div_done;
   logic signed [NUM_W-1:0] numer, quot;
   logic signed [NUM_W-1:0] sum;

   logic [SLOT_W-1:0] rd_addr, wr_addr;
   logic              wr_en, wr_stat;
   logic [31:0] time_q, count_q;
   logic [15:0] chg_q;
   logic [30:0] evt_q, digi_q;
   logic [39:0] mean_q;
   logic [31:0] count_wr;
   logic [39:0] mean_wr;
   logic [47:0] time_store;

   // hold the read address on the item in work so the record stays put
   assign rd_addr = (state_ff == ST_IDLE) ? q_item.slot[SLOT_W-1:0]
                                          : it_ff.slot[SLOT_W-1:0];
   assign wr_en   = (state_ff == ST_WRITE);
   assign wr_stat = wr_en || (state_ff == ST_CLEAR);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff[SLOT_W-1:0] : it_ff.slot[SLOT_W-1:0];
   assign count_wr = (state_ff == ST_CLEAR) ? '0 :
                     ((count_q == 32'hFFFF_FFFF) ? count_q : count_q + 32'd1);
   assign mean_wr  = (state_ff == ST_CLEAR) ? '0 : newmean_ff;
   assign time_store = it_ff.time_stamp;

   shim_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(time_store[31:0]),
      .rd_addr(rd_addr), .rd_data(time_q));
   shim_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_chg (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(it_ff.charge),
      .rd_addr(rd_addr), .rd_data(chg_q));
   shim_ram #(.WIDTH(31), .DEPTH(DEPTH)) u_evt (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(it_ff.event_number),
      .rd_addr(rd_addr), .rd_data(evt_q));
   shim_ram #(.WIDTH(31), .DEPTH(DEPTH)) u_digi (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(it_ff.digi_number),
      .rd_addr(rd_addr), .rd_data(digi_q));
   shim_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_cnt (
      .clock(clock), .wr_en(wr_stat), .wr_addr(wr_addr), .wr_data(count_wr),
      .rd_addr(rd_addr), .rd_data(count_q));
   shim_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_mean (
      .clock(clock), .wr_en(wr_stat), .wr_addr(wr_addr), .wr_data(mean_wr),
      .rd_addr(rd_addr), .rd_data(mean_q));

   // dt*256 - mean, 50 bits hold it for time widths up to 40 bits
   always_comb begin
      numer = (NUM_W'($signed({2'b0, it_ff.time_stamp})) -
               NUM_W'($signed({2'b0, 16'd0, time_q}))) <<< 8;
      numer = numer - NUM_W'($signed(mean_q));
   end

   shim_divider #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(numer),
      .denom(count_q), .done(div_done), .quot(quot));

   assign div_start = (state_ff == ST_EVAL) && (it_ff.cmd == shim_pkg::CMD_RECORD)
                      && it_ff.valid_chan && (count_q != 32'd0);
   assign sum   = NUM_W'($signed(mean_q)) + quot;
   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (q_valid) begin
                  it_ff    <= q_item;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_EVAL;
            ST_EVAL: begin
               rsp_never_hit     <= 1'b1;
               rsp_last_time     <= '0;
               rsp_elapsed       <= '0;
               rsp_mean_interval <= '0;
               rsp_hit_count     <= '0;
               rsp_last_charge   <= '0;
               rsp_last_event    <= '0;
               rsp_last_digi     <= '0;
               newmean_ff        <= mean_q;
               if (!it_ff.valid_chan) begin
                  rsp_valid <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else if (it_ff.cmd == shim_pkg::CMD_RECORD) begin
                  state_ff <= (count_q != 32'd0) ? ST_DIV : ST_WRITE;
               end else begin
                  rsp_valid <= 1'b1;
                  state_ff  <= ST_IDLE;
                  if (count_q != 32'd0) begin
                     rsp_never_hit     <= 1'b0;
                     rsp_last_time     <= time_q;
                     rsp_mean_interval <= mean_q;
                     rsp_hit_count     <= count_q;
                     rsp_last_charge   <= chg_q;
                     rsp_last_event    <= evt_q;
                     rsp_last_digi     <= digi_q;
                     if (it_ff.cmd == shim_pkg::CMD_ELAPSED) begin
                        rsp_elapsed <= $signed({1'b0, it_ff.time_stamp[31:0]}) -
                                       $signed({1'b0, time_q});
                     end
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  // clamp to the signed 40-bit range
                  if (sum > NUM_W'(64'sh7F_FFFF_FFFF)) begin
                     newmean_ff <= 40'sh7F_FFFF_FFFF;
                  end else if (sum < -NUM_W'(64'sh80_0000_0000)) begin
                     newmean_ff <= -40'sh80_0000_0000;
                  end else begin
                     newmean_ff <= sum[39:0];
                  end
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               rsp_valid         <= 1'b1;
               rsp_never_hit     <= 1'b0;
               rsp_last_time     <= time_store[31:0];
               rsp_elapsed       <= '0;
               rsp_mean_interval <= newmean_ff;
               rsp_hit_count     <= count_wr;
               rsp_last_charge   <= it_ff.charge;
               rsp_last_event    <= it_ff.event_number;
               rsp_last_digi     <= it_ff.digi_number;
               state_ff          <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

### rtl/core/shim_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// shim_checker
// Port-level checks on the monitor, bound to the top level.
// ----------------------------------------------------------------------------
module shim_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_never_hit,
   input logic [31:0] rsp_hit_count,
   input logic [32:0] rsp_elapsed,
   input logic [31:0] rsp_last_time
);
   `SHIM_ASSERT_IMP(a_never_zero_count, clock, reset, rsp_valid && rsp_never_hit,
      rsp_hit_count == 32'd0, "never-hit result with nonzero count")
   `SHIM_ASSERT_IMP(a_hit_count, clock, reset, rsp_valid && !rsp_never_hit,
      rsp_hit_count != 32'd0, "hit result with zero count")
   `SHIM_ASSERT_IMP(a_never_fields, clock, reset, rsp_valid && rsp_never_hit,
      rsp_elapsed == 33'd0 && rsp_last_time == 32'd0, "never-hit fields not zero")
   `SHIM_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid,
      "result strobe held two cycles")
endmodule

bind strip_hit_interval_monitor_core shim_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid),
   .rsp_never_hit(rsp_never_hit), .rsp_hit_count(rsp_hit_count),
   .rsp_elapsed(rsp_elapsed), .rsp_last_time(rsp_last_time));
